// ----- rtl/pcb_pkg.sv -----
// pcb_pkg: shared types and constants of the pixel convert and blend engine.
// No dependencies; imported by every module under rtl/.
package pcb_pkg;

	localparam int unsigned FMT_W = 3;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	typedef logic [FMT_W-1:0] fmt_t;
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

	localparam fmt_t FMT_RGB565   = 3'd0;
	localparam fmt_t FMT_RGB888   = 3'd1;
	localparam fmt_t FMT_XRGB8888 = 3'd2;
	localparam fmt_t FMT_ARGB8888 = 3'd3;
	localparam fmt_t FMT_A8       = 3'd4;

	localparam cfg_addr_t CFG_MODE         = 3'd0;
	localparam cfg_addr_t CFG_SOURCE_FMT   = 3'd1;
	localparam cfg_addr_t CFG_BACK_FMT     = 3'd2;
	localparam cfg_addr_t CFG_TARGET_FMT   = 3'd3;
	localparam cfg_addr_t CFG_FILL_COLOR   = 3'd4;
	localparam cfg_addr_t CFG_GLOBAL_ALPHA = 3'd5;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [15:0] ROUND_HALF = 16'd127;

	localparam logic [2:0] BYTES_NONE = 3'd0;
	localparam logic [2:0] BYTES_565  = 3'd2;
	localparam logic [2:0] BYTES_888  = 3'd3;
	localparam logic [2:0] BYTES_8888 = 3'd4;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pix_t;

	// one classified request, as held in the queue
	typedef struct packed {
		logic       err;
		logic       blend;
		fmt_t       target;
		logic [7:0] galpha;
		pix_t       fg;
		pix_t       bg;
	} job_t;

	localparam int unsigned JOB_W = $bits(job_t);

endpackage

// ----- rtl/pixel_convert_blend_top.sv -----
// pixel_convert_blend_top: pixel format convert and alpha blend engine.
// Depends on pcb_pkg, pcb_front, pcb_queue, pcb_back.
//
//  channel  | dir | handshake          | content
//  ---------+-----+--------------------+-------------------------------------
//  config   | in  | cfg_we             | cfg_addr index, cfg_wdata value
//  s_*      | in  | s_tvalid/s_tready  | front_word, back_word
//  m_*      | out | m_tvalid/m_tready  | dest_word, dest_bytes; status in tuser
//
// One request per clock while the output is not stalled; an accepted request passes
// the queue, the alpha stage, the mix stage and the output register to m_tvalid.
// Reset clears configuration, queue and stage valid flags only.
// A stalled output holds the back stages; the front keeps taking requests
// until the queue is full.
module pixel_convert_blend_top
	import pcb_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_addr_t             cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,   // front_word[31:0], back_word[63:32]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // dest_word[31:0], dest_bytes[34:32], zero
	output logic                  m_tuser    // status[0]
);

	logic push;
	job_t push_job;
	logic q_full;
	logic q_pop;
	logic q_nonempty;
	job_t q_head;

	pcb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	pcb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	pcb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ----- rtl/pcb_front.sv -----
// pcb_front: configuration registers, format check and pixel unpack.
// Depends on pcb_pkg; feeds pcb_queue.
module pcb_front
	import pcb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_addr_t             cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,
	input  logic                  q_full,
	output logic                  push,
	output job_t                  job
);

	logic        mode_q;
	fmt_t        source_fmt_q;
	fmt_t        back_fmt_q;
	fmt_t        target_fmt_q;
	logic [23:0] fill_color_q;
	logic [7:0]  global_alpha_q;
	logic        ok;
	pix_t        fg_raw;

	function automatic pix_t unpack(input logic [31:0] w, input fmt_t f);
		pix_t p;
		p.a = ALPHA_OPAQUE;
		case (f)
			FMT_RGB565: begin
				p.r = {w[15:11], w[15:13]};
				p.g = {w[10:5], w[10:9]};
				p.b = {w[4:0], w[4:2]};
			end
			FMT_RGB888: begin
				p.r = w[7:0];
				p.g = w[15:8];
				p.b = w[23:16];
			end
			FMT_A8: begin
				p.r = 8'd0;
				p.g = 8'd0;
				p.b = 8'd0;
				p.a = w[7:0];
			end
			default: begin
				p.b = w[7:0];
				p.g = w[15:8];
				p.r = w[23:16];
				if (f == FMT_ARGB8888) begin
					p.a = w[31:24];
				end
			end
		endcase
		return p;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			source_fmt_q   <= FMT_RGB565;
			back_fmt_q     <= FMT_RGB565;
			target_fmt_q   <= FMT_RGB565;
			fill_color_q   <= 24'd0;
			global_alpha_q <= ALPHA_OPAQUE;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MODE:         mode_q         <= cfg_wdata[0];
				CFG_SOURCE_FMT:   source_fmt_q   <= cfg_wdata[FMT_W-1:0];
				CFG_BACK_FMT:     back_fmt_q     <= cfg_wdata[FMT_W-1:0];
				CFG_TARGET_FMT:   target_fmt_q   <= cfg_wdata[FMT_W-1:0];
				CFG_FILL_COLOR:   fill_color_q   <= cfg_wdata[23:0];
				CFG_GLOBAL_ALPHA: global_alpha_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (mode_q) begin
			ok = (source_fmt_q inside {[FMT_RGB565:FMT_A8]}) &&
			     (back_fmt_q inside {[FMT_RGB565:FMT_ARGB8888]}) &&
			     (target_fmt_q inside {[FMT_RGB565:FMT_ARGB8888]});
		end else begin
			ok = (source_fmt_q inside {[FMT_RGB565:FMT_ARGB8888]}) &&
			     (target_fmt_q inside {[FMT_RGB565:FMT_ARGB8888]});
		end
	end

	always_comb begin
		fg_raw = unpack(s_tdata[31:0], source_fmt_q);
		if (source_fmt_q == FMT_A8) begin
			fg_raw.r = fill_color_q[23:16];
			fg_raw.g = fill_color_q[15:8];
			fg_raw.b = fill_color_q[7:0];
		end
		job.err    = !ok;
		job.blend  = mode_q;
		job.target = target_fmt_q;
		job.galpha = global_alpha_q;
		job.fg     = fg_raw;
		job.bg     = unpack(s_tdata[63:32], back_fmt_q);
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

endmodule

// ----- rtl/pcb_queue.sv -----
// pcb_queue: short FIFO of classified requests between front and back.
// Depends on pcb_pkg.
module pcb_queue
	import pcb_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output job_t head
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_pop   = pop && nonempty;
	assign head     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/pcb_back.sv -----
// pcb_back: three-stage alpha scale, channel mix, and repack into the output register.
// Depends on pcb_pkg; takes requests from pcb_queue.
module pcb_back
	import pcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  job_t        q_head,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic        m_tuser
);

	logic        en;
	logic        v_s1, v_s2;
	job_t        job_s1, job_s2;
	logic [15:0] aprod_s1;
	logic [15:0] sum_r_s2, sum_g_s2, sum_b_s2;
	logic [7:0]  alpha;
	logic [7:0]  alpha_inv;
	pix_t        px;
	logic [31:0] word;
	logic [2:0]  nbytes;
	logic        out_valid_q;
	logic [31:0] word_q;
	logic [2:0]  nbytes_q;
	logic        err_q;

	// exact x/255 for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [15:0] mix(input logic [7:0] f, input logic [7:0] b,
	                                    input logic [7:0] a, input logic [7:0] na);
		return 16'(f * a) + 16'(b * na) + ROUND_HALF;
	endfunction

	assign en    = !out_valid_q || m_tready;
	assign q_pop = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= q_nonempty;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign alpha     = div255(aprod_s1);
	assign alpha_inv = ALPHA_OPAQUE - alpha;

	always_ff @(posedge clk) begin
		if (en) begin
			job_s1   <= q_head;
			aprod_s1 <= 16'(q_head.fg.a * q_head.galpha) + ROUND_HALF;
			job_s2   <= job_s1;
			sum_r_s2 <= mix(job_s1.fg.r, job_s1.bg.r, alpha, alpha_inv);
			sum_g_s2 <= mix(job_s1.fg.g, job_s1.bg.g, alpha, alpha_inv);
			sum_b_s2 <= mix(job_s1.fg.b, job_s1.bg.b, alpha, alpha_inv);
			word_q   <= word;
			nbytes_q <= nbytes;
			err_q    <= job_s2.err;
		end
	end

	always_comb begin
		if (job_s2.blend) begin
			px.r = div255(sum_r_s2);
			px.g = div255(sum_g_s2);
			px.b = div255(sum_b_s2);
			px.a = ALPHA_OPAQUE;
		end else begin
			px = job_s2.fg;
		end
		case (job_s2.target)
			FMT_RGB565: begin
				word   = {16'd0, px.r[7:3], px.g[7:2], px.b[7:3]};
				nbytes = BYTES_565;
			end
			FMT_RGB888: begin
				word   = {8'd0, px.b, px.g, px.r};
				nbytes = BYTES_888;
			end
			FMT_ARGB8888: begin
				word   = {px.a, px.r, px.g, px.b};
				nbytes = BYTES_8888;
			end
			default: begin
				word   = {ALPHA_OPAQUE, px.r, px.g, px.b};
				nbytes = BYTES_8888;
			end
		endcase
		if (job_s2.err) begin
			word   = 32'd0;
			nbytes = BYTES_NONE;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, nbytes_q, word_q};
	assign m_tuser  = err_q;

endmodule

// ----- rtl/pcb_checker.sv -----
// pcb_checker: port-level assertions for pixel_convert_blend_top.
// Depends on pcb_pkg; attached to the top level by the bind below.
module pcb_checker
	import pcb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 40'd0)
		else $error("error result not zero");

	a_ok_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
		m_tdata[34:32] == BYTES_565 || m_tdata[34:32] == BYTES_888 ||
		m_tdata[34:32] == BYTES_8888)
		else $error("bad byte count");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:35] == 5'd0 &&
		(m_tdata[34:32] != BYTES_565 || m_tdata[31:16] == 16'd0) &&
		(m_tdata[34:32] != BYTES_888 || m_tdata[31:24] == 8'd0))
		else $error("unused bytes not zero");

endmodule

bind pixel_convert_blend_top pcb_checker u_pcb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- tb/tb.sv -----
// tb: self-checking bench for pixel_convert_blend_top, format conversion and alpha blend.
// Depends on pcb_pkg and the RTL under rtl/; a directed table, then random phases, most
// with random sender gaps or receiver stalls; results checked against table or predictor.
module tb;
	import pcb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic ST_OK = 1'b0;
	localparam logic ST_BAD = 1'b1;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned ITEMS_PER_PHASE = 175;

	typedef struct packed {
		logic        blend;
		fmt_t        src;
		fmt_t        bkg;
		fmt_t        tgt;
		logic [23:0] fill;
		logic [7:0]  galpha;
	} blit_cfg_t;

	typedef struct packed {
		logic [31:0] dest_word;
		logic [2:0]  dest_bytes;
		logic        status;
	} pixel_out_t;

	typedef struct packed {
		blit_cfg_t   setup;
		logic [31:0] front;
		logic [31:0] back;
		logic        known;
		pixel_out_t  want;
	} vec_t;

	localparam pixel_out_t BAD_FORMAT = {32'h0, BYTES_NONE, ST_BAD};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	cfg_addr_t             cfg_addr = CFG_MODE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata = '0;   // front_word[31:0], back_word[63:32]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [39:0]           m_tdata;        // dest_word[31:0], dest_bytes[34:32], zero
	logic                  m_tuser;        // status[0]

	blit_cfg_t    cur_cfg;
	pixel_out_t   pending[$];
	vec_t         directed[$];
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  error_count = 0;
	int unsigned  cycle_count = 0;

	pixel_convert_blend_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	function automatic blit_cfg_t mk_cfg(logic blend, fmt_t src, fmt_t bkg, fmt_t tgt,
			logic [23:0] fill, logic [7:0] galpha);
		blit_cfg_t c;
		c.blend = blend;
		c.src = src;
		c.bkg = bkg;
		c.tgt = tgt;
		c.fill = fill;
		c.galpha = galpha;
		return c;
	endfunction

	function automatic bit is_colour(fmt_t f);
		return f <= FMT_ARGB8888;
	endfunction

	function automatic pix_t unpack_pixel(logic [31:0] w, fmt_t f);
		pix_t p;
		p.a = ALPHA_OPAQUE;
		case (f)
			FMT_RGB565: begin
				p.r = {w[15:11], w[15:13]};
				p.g = {w[10:5], w[10:9]};
				p.b = {w[4:0], w[4:2]};
			end
			FMT_RGB888: begin
				p.r = w[7:0];
				p.g = w[15:8];
				p.b = w[23:16];
			end
			FMT_A8: begin
				p.r = 8'h00;
				p.g = 8'h00;
				p.b = 8'h00;
				p.a = w[7:0];
			end
			default: begin
				p.b = w[7:0];
				p.g = w[15:8];
				p.r = w[23:16];
				if (f == FMT_ARGB8888)
					p.a = w[31:24];
			end
		endcase
		return p;
	endfunction

	function automatic pixel_out_t pack_pixel(pix_t p, fmt_t f);
		pixel_out_t res;
		res.status = ST_OK;
		case (f)
			FMT_RGB565: begin
				res.dest_word = {16'h0, p.r[7:3], p.g[7:2], p.b[7:3]};
				res.dest_bytes = BYTES_565;
			end
			FMT_RGB888: begin
				res.dest_word = {8'h0, p.b, p.g, p.r};
				res.dest_bytes = BYTES_888;
			end
			default: begin
				res.dest_word = {(f == FMT_ARGB8888) ? p.a : ALPHA_OPAQUE, p.r, p.g, p.b};
				res.dest_bytes = BYTES_8888;
			end
		endcase
		return res;
	endfunction

	function automatic logic [7:0] mix_channel(int unsigned f, int unsigned b, int unsigned a);
		return 8'((f * a + b * (255 - a) + 127) / 255);
	endfunction

	function automatic pixel_out_t predict_pixel(blit_cfg_t c, logic [31:0] fw, logic [31:0] bw);
		pix_t fg;
		pix_t bg;
		int unsigned a;
		bit ok;
		if (!c.blend)
			ok = is_colour(c.src) && is_colour(c.tgt);
		else
			ok = (is_colour(c.src) || c.src == FMT_A8) && is_colour(c.bkg) && is_colour(c.tgt);
		if (!ok)
			return BAD_FORMAT;
		fg = unpack_pixel(fw, c.src);
		if (!c.blend) begin
			if (c.src != FMT_ARGB8888)
				fg.a = ALPHA_OPAQUE;
		end else begin
			bg = unpack_pixel(bw, c.bkg);
			if (c.src == FMT_A8)
				{fg.r, fg.g, fg.b} = c.fill;
			a = (int'(fg.a) * int'(c.galpha) + 127) / 255;
			fg.r = mix_channel(fg.r, bg.r, a);
			fg.g = mix_channel(fg.g, bg.g, a);
			fg.b = mix_channel(fg.b, bg.b, a);
			fg.a = ALPHA_OPAQUE;
		end
		return pack_pixel(fg, c.tgt);
	endfunction

	function automatic blit_cfg_t rand_cfg();
		blit_cfg_t c;
		c.blend = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 4) != 0) begin
			c.src = c.blend ? fmt_t'($urandom_range(0, 4)) : fmt_t'($urandom_range(0, 3));
			c.bkg = fmt_t'($urandom_range(0, 3));
			c.tgt = fmt_t'($urandom_range(0, 3));
		end else begin
			c.src = fmt_t'($urandom_range(0, 7));
			c.bkg = fmt_t'($urandom_range(0, 7));
			c.tgt = fmt_t'($urandom_range(0, 7));
		end
		case ($urandom_range(0, 5))
			0: c.fill = 24'h000000;
			1: c.fill = 24'hFFFFFF;
			default: c.fill = 24'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: c.galpha = 8'h00;
			1: c.galpha = 8'hFF;
			2: c.galpha = 8'h01;
			3: c.galpha = 8'hFE;
			default: c.galpha = 8'($urandom);
		endcase
		return c;
	endfunction

	function automatic void add_vec(blit_cfg_t c, logic [31:0] fw, logic [31:0] bw,
			logic known, pixel_out_t want);
		vec_t v;
		v.setup = c;
		v.front = fw;
		v.back = bw;
		v.known = known;
		v.want = want;
		directed.push_back(v);
	endfunction

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_addr_t idx, logic [CFG_DATA_W-1:0] value, int unsigned width);
		logic [CFG_DATA_W-1:0] spare;
		spare = CFG_DATA_W'($urandom);
		spare = (width >= CFG_DATA_W) ? '0 : (spare >> width) << width;
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= spare | value;
		@(posedge clk);
	endtask

	task automatic load_config(blit_cfg_t c);
		hold_until_drained();
		// indexes past the last register must be ignored
		if ($urandom_range(0, 3) == 0)
			write_reg(cfg_addr_t'(CFG_GLOBAL_ALPHA + 1 + $urandom_range(0, 1)),
				CFG_DATA_W'($urandom), 0);
		write_reg(CFG_MODE, CFG_DATA_W'(c.blend), 1);
		write_reg(CFG_SOURCE_FMT, CFG_DATA_W'(c.src), FMT_W);
		write_reg(CFG_BACK_FMT, CFG_DATA_W'(c.bkg), FMT_W);
		write_reg(CFG_TARGET_FMT, CFG_DATA_W'(c.tgt), FMT_W);
		write_reg(CFG_FILL_COLOR, c.fill, 24);
		write_reg(CFG_GLOBAL_ALPHA, CFG_DATA_W'(c.galpha), 8);
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	task automatic send_pixel(logic [31:0] fw, logic [31:0] bw, logic known, pixel_out_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom, $urandom};
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {bw, fw};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending.push_back(known ? want : predict_pixel(cur_cfg, fw, bw));
	endtask

	always @(posedge clk) begin
		pixel_out_t got;
		pixel_out_t exp_px;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[34:32], m_tuser};
			if (pending.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("unexpected result: word %h bytes %0d status %0d",
						got.dest_word, got.dest_bytes, got.status);
				error_count++;
			end else begin
				exp_px = pending.pop_front();
				if (got.dest_word != exp_px.dest_word || got.dest_bytes != exp_px.dest_bytes ||
						got.status != exp_px.status) begin
					if (error_count < MAX_REPORTS)
						$display("mismatch: word %h/%h bytes %0d/%0d status %0d/%0d (exp/got)",
							exp_px.dest_word, got.dest_word, exp_px.dest_bytes,
							got.dest_bytes, exp_px.status, got.status);
					error_count++;
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		blit_cfg_t c;
		vec_t v;
		logic [31:0] fw;
		logic [31:0] bw;
		int unsigned sent;
		int unsigned n;
		cur_cfg = mk_cfg(1'b0, FMT_RGB565, FMT_RGB565, FMT_RGB565, 24'h0, 8'hFF);

		// reset values, 565 identity and ignored upper bytes
		c = cur_cfg;
		add_vec(c, 32'h0000_FFFF, 32'hFFFF_FFFF, 1'b1, {32'h0000_FFFF, BYTES_565, ST_OK});
		add_vec(c, 32'hFFFF_0000, 32'h0000_0000, 1'b1, {32'h0000_0000, BYTES_565, ST_OK});
		add_vec(c, 32'hDEAD_F81F, 32'h0000_0000, 1'b1, {32'h0000_F81F, BYTES_565, ST_OK});
		c = mk_cfg(1'b0, FMT_ARGB8888, FMT_RGB565, FMT_ARGB8888, 24'h0, 8'hFF);
		add_vec(c, 32'h1234_5678, 32'h0, 1'b1, {32'h1234_5678, BYTES_8888, ST_OK});
		add_vec(c, 32'hFFFF_FFFF, 32'h0, 1'b1, {32'hFFFF_FFFF, BYTES_8888, ST_OK});
		c = mk_cfg(1'b0, FMT_XRGB8888, FMT_RGB565, FMT_ARGB8888, 24'h0, 8'hFF);
		add_vec(c, 32'h1234_5678, 32'h0, 1'b1, {32'hFF34_5678, BYTES_8888, ST_OK});
		c = mk_cfg(1'b0, FMT_RGB888, FMT_RGB565, FMT_XRGB8888, 24'h0, 8'hFF);
		add_vec(c, 32'hAABB_CCDD, 32'h0, 1'b1, {32'hFFDD_CCBB, BYTES_8888, ST_OK});
		c = mk_cfg(1'b0, FMT_RGB565, FMT_RGB565, FMT_RGB888, 24'h0, 8'hFF);
		add_vec(c, 32'hFFFF_FFFF, 32'h0, 1'b1, {32'h00FF_FFFF, BYTES_888, ST_OK});
		c = mk_cfg(1'b0, FMT_ARGB8888, FMT_RGB565, FMT_RGB565, 24'h0, 8'hFF);
		add_vec(c, 32'h00FF_FFFF, 32'h0, 1'b1, {32'h0000_FFFF, BYTES_565, ST_OK});
		// bad combinations in convert mode; the background format does not matter there
		c = mk_cfg(1'b0, FMT_A8, FMT_RGB565, FMT_RGB565, 24'h0, 8'hFF);
		add_vec(c, 32'hFFFF_FFFF, 32'h0, 1'b1, BAD_FORMAT);
		c = mk_cfg(1'b0, fmt_t'(7), FMT_RGB565, FMT_XRGB8888, 24'h0, 8'hFF);
		add_vec(c, 32'h1234_5678, 32'h0, 1'b1, BAD_FORMAT);
		c = mk_cfg(1'b0, FMT_RGB565, FMT_A8, fmt_t'(5), 24'h0, 8'hFF);
		add_vec(c, 32'h1234_5678, 32'h0, 1'b1, BAD_FORMAT);
		c = mk_cfg(1'b0, FMT_RGB888, fmt_t'(6), FMT_RGB888, 24'h0, 8'hFF);
		add_vec(c, 32'hFF12_3456, 32'h0, 1'b1, {32'h0012_3456, BYTES_888, ST_OK});
		// blend: opaque, transparent, zero global alpha
		c = mk_cfg(1'b1, FMT_ARGB8888, FMT_XRGB8888, FMT_XRGB8888, 24'h0, 8'hFF);
		add_vec(c, 32'hFF11_2233, 32'h00AA_BBCC, 1'b1, {32'hFF11_2233, BYTES_8888, ST_OK});
		add_vec(c, 32'h0011_2233, 32'h00AA_BBCC, 1'b1, {32'hFFAA_BBCC, BYTES_8888, ST_OK});
		c = mk_cfg(1'b1, FMT_ARGB8888, FMT_XRGB8888, FMT_XRGB8888, 24'h0, 8'h00);
		add_vec(c, 32'hFF11_2233, 32'h44AA_BBCC, 1'b1, {32'hFFAA_BBCC, BYTES_8888, ST_OK});
		// alpha-only foreground takes its colour from the fill register
		c = mk_cfg(1'b1, FMT_A8, FMT_RGB888, FMT_RGB888, 24'h123456, 8'hFF);
		add_vec(c, 32'h0000_00FF, 32'h0, 1'b1, {32'h0056_3412, BYTES_888, ST_OK});
		c = mk_cfg(1'b1, FMT_A8, FMT_RGB565, FMT_ARGB8888, 24'hFFFFFF, 8'hFF);
		add_vec(c, 32'hFFFF_FF80, 32'h1234_0000, 1'b0, '0);
		// bad combinations in blend mode
		c = mk_cfg(1'b1, FMT_RGB565, FMT_A8, FMT_XRGB8888, 24'h0, 8'hFF);
		add_vec(c, 32'h1234_5678, 32'h0, 1'b1, BAD_FORMAT);
		c = mk_cfg(1'b1, FMT_RGB565, FMT_RGB565, FMT_A8, 24'h0, 8'hFF);
		add_vec(c, 32'h1234_5678, 32'h0, 1'b1, BAD_FORMAT);
		c = mk_cfg(1'b1, fmt_t'(6), FMT_RGB565, FMT_RGB565, 24'h0, 8'hFF);
		add_vec(c, 32'h1234_5678, 32'h0, 1'b1, BAD_FORMAT);
		c = mk_cfg(1'b1, FMT_RGB565, fmt_t'(7), FMT_RGB565, 24'h0, 8'hFF);
		add_vec(c, 32'h1234_5678, 32'h0, 1'b1, BAD_FORMAT);
		// partial alpha, then an opaque colour foreground
		c = mk_cfg(1'b1, FMT_RGB565, FMT_RGB888, FMT_RGB565, 24'h0, 8'h80);
		add_vec(c, 32'h1234_F81F, 32'h00FF_8000, 1'b0, '0);
		c = mk_cfg(1'b1, FMT_ARGB8888, FMT_ARGB8888, FMT_ARGB8888, 24'h0, 8'h01);
		add_vec(c, 32'h80FF_00FF, 32'hFF00_FF00, 1'b0, '0);
		c = mk_cfg(1'b1, FMT_XRGB8888, FMT_RGB565, FMT_RGB565, 24'hABCDEF, 8'hFF);
		add_vec(c, 32'hFF00_0000, 32'hFFFF_FFFF, 1'b1, {32'h0000_0000, BYTES_565, ST_OK});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			v = directed[i];
			if (v.setup != cur_cfg)
				load_config(v.setup);
			send_pixel(v.front, v.back, v.known, v.want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 45; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 45; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				load_config(rand_cfg());
				n = $urandom_range(8, 40);
				if (n > ITEMS_PER_PHASE - sent)
					n = ITEMS_PER_PHASE - sent;
				repeat (n) begin
					fw = $urandom;
					bw = $urandom;
					if ($urandom_range(0, 3) == 0)
						fw[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					if ($urandom_range(0, 3) == 0)
						fw[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					if ($urandom_range(0, 59) == 0)
						hold_until_drained();
					send_pixel(fw, bw, 1'b0, '0);
					sent++;
				end
			end
		end

		hold_until_drained();
		if (error_count == 0 && pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
